// ----- rtl/gbp_pkg.sv -----
// shared types, codes and constants for the gps baud probe and configure sequencer
package gbp_pkg;

   localparam int BAUD_COUNT_DEF      = 6;
   localparam int FAST_BAUD_INDEX_DEF = 3;
   localparam int PROBE_FRAMES_DEF    = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_FRAME    = 3'd1,
      OP_ACK      = 3'd2,
      OP_NAK      = 3'd3,
      OP_POSITION = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      MODE_PROBE  = 3'd0,
      MODE_NEWCFG = 3'd1,
      MODE_LEGACY = 3'd2,
      MODE_RAISE  = 3'd3,
      MODE_RUN    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ACK_IDLE = 2'd0,
      ACK_OK   = 2'd1,
      ACK_NAK  = 2'd2
   } ack_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TX_PRESENT     = 3'd0,
      CSR_PROBE_DWELL    = 3'd1,
      CSR_ACK_TIMEOUT    = 3'd2,
      CSR_SILENCE        = 3'd3,
      CSR_BAUD_SETTLE    = 3'd4,
      CSR_BAUD_VERIFY    = 3'd5,
      CSR_MAX_ATTEMPTS   = 3'd6
   } csr_index_type;

   // candidate baud rates, extra indices count as fast
   localparam logic [17:0] BAUD_RATE_TABLE [0:7] = '{
      18'd115200, 18'd9600, 18'd38400, 18'd57600,
      18'd230400, 18'd19200, 18'd115200, 18'd115200
   };

   localparam logic [17:0] BAUD_MID = 18'd38400;
   localparam logic [17:0] BAUD_LOW = 18'd19200;

   localparam logic [8:0] NAV_RATE_FAST = 9'd100;
   localparam logic [8:0] NAV_RATE_MID  = 9'd200;
   localparam logic [8:0] NAV_RATE_SLOW = 9'd500;

   localparam logic [1:0] ATTEMPT_MAX = 2'd3;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] port_baud_index;
      logic       port_retune;
      logic       drain_tx;
      logic       send_new_config;
      logic       send_legacy_config;
      logic       disable_nmea;
      logic [8:0] nav_rate_ms;
      logic       send_baud_change;
      logic       config_applied;
      logic       used_new_config;
   } result_type;

endpackage

// ----- rtl/gbp_if.sv -----
// channel interfaces for events, results and register writes
interface gbp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] now_ms;
   modport source (output valid, op, now_ms, input ready);
   modport sink (input valid, op, now_ms, output ready);
endinterface

interface gbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [2:0] port_baud_index;
   logic       port_retune;
   logic       drain_tx;
   logic       send_new_config;
   logic       send_legacy_config;
   logic       disable_nmea;
   logic [8:0] nav_rate_ms;
   logic       send_baud_change;
   logic       config_applied;
   logic       used_new_config;
   modport source (output valid, mode, port_baud_index, port_retune, drain_tx,
                   send_new_config, send_legacy_config, disable_nmea, nav_rate_ms,
                   send_baud_change, config_applied, used_new_config, input ready);
   modport sink (input valid, mode, port_baud_index, port_retune, drain_tx,
                 send_new_config, send_legacy_config, disable_nmea, nav_rate_ms,
                 send_baud_change, config_applied, used_new_config, output ready);
endinterface

interface gbp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gbp_pkg::CSR_INDEX_W-1:0]  index;
   logic [gbp_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/gps_baud_probe_configure_fsm_core.sv -----
// gps link sequencer: baud probing, module configuration and link supervision
//
// req_if carries one event per transaction (op and a millisecond time stamp).
// every event yields exactly one result transaction on rsp_if with the current
// mode, the port baud index and the command flags raised by that event.
// csr_if writes the tx present, timing and attempt registers; it is always ready.
// an accepted event lands in an input register, the step logic runs in the
// next cycle and the result is held in an output register. one event per
// cycle is sustained while rsp_if does not stall, set by the combinational
// step logic between the two registers.
// when rsp_if stalls the result waits in the output register while one more
// event is held in the input register; req_if.ready drops only when both are
// full. reset returns to probing at baud index 0 with all registers at their
// defaults, no pending events and no pending result.
module gps_baud_probe_configure_fsm_core #(
   parameter int BAUD_COUNT      = gbp_pkg::BAUD_COUNT_DEF,
   parameter int FAST_BAUD_INDEX = gbp_pkg::FAST_BAUD_INDEX_DEF,
   parameter int PROBE_FRAMES    = gbp_pkg::PROBE_FRAMES_DEF
) (
   input logic        clock,
   input logic        reset,
   gbp_req_if.sink    req_if,
   gbp_rsp_if.source  rsp_if,
   gbp_csr_if.sink    csr_if
);
   import gbp_pkg::*;

   // configuration registers
   logic        tx_present_ff;
   logic [15:0] probe_dwell_ff;
   logic [15:0] ack_timeout_ff;
   logic [15:0] silence_ff;
   logic [15:0] baud_settle_ff;
   logic [15:0] baud_verify_ff;
   logic [1:0]  max_attempts_ff;

   // pipeline registers
   logic        in_valid_ff;
   logic [2:0]  in_op_ff;
   logic [31:0] in_now_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        advance;

   // sequencer state
   mode_type    mode_ff, mode_in;
   logic [2:0]  baud_ff, baud_in;
   logic [2:0]  prior_ff, prior_in;
   logic [1:0]  good_ff, good_in;
   logic [1:0]  attempt_ff, attempt_in;
   logic [31:0] entered_ff, entered_in;
   logic [31:0] last_frame_ff, last_frame_in;
   logic [31:0] last_pos_ff, last_pos_in;
   ack_type     ack_ff, ack_in;
   logic        pos_seen_ff, pos_seen_in;
   logic        raise_done_ff, raise_done_in;
   logic        switched_ff, switched_in;
   logic        applied_ff, applied_in;
   logic        new_form_ff, new_form_in;

   result_type  res;
   logic [2:0]  baud_wrap;
   logic [3:0]  wrap_v;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_present_ff   <= 1'b1;
         probe_dwell_ff  <= 16'd2500;
         ack_timeout_ff  <= 16'd1100;
         silence_ff      <= 16'd5000;
         baud_settle_ff  <= 16'd150;
         baud_verify_ff  <= 16'd2000;
         max_attempts_ff <= 2'd3;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_TX_PRESENT:   tx_present_ff   <= csr_if.data[0];
            CSR_PROBE_DWELL:  probe_dwell_ff  <= csr_if.data;
            CSR_ACK_TIMEOUT:  ack_timeout_ff  <= csr_if.data;
            CSR_SILENCE:      silence_ff      <= csr_if.data;
            CSR_BAUD_SETTLE:  baud_settle_ff  <= csr_if.data;
            CSR_BAUD_VERIFY:  baud_verify_ff  <= csr_if.data;
            CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_if.data[1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         in_op_ff  <= req_if.op;
         in_now_ff <= req_if.now_ms;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PROBE;
         baud_ff       <= 3'd0;
         prior_ff      <= 3'd0;
         good_ff       <= 2'd0;
         attempt_ff    <= 2'd0;
         entered_ff    <= 32'd0;
         last_frame_ff <= 32'd0;
         last_pos_ff   <= 32'd0;
         ack_ff        <= ACK_IDLE;
         pos_seen_ff   <= 1'b0;
         raise_done_ff <= 1'b0;
         switched_ff   <= 1'b0;
         applied_ff    <= 1'b0;
         new_form_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         baud_ff       <= baud_in;
         prior_ff      <= prior_in;
         good_ff       <= good_in;
         attempt_ff    <= attempt_in;
         entered_ff    <= entered_in;
         last_frame_ff <= last_frame_in;
         last_pos_ff   <= last_pos_in;
         ack_ff        <= ack_in;
         pos_seen_ff   <= pos_seen_in;
         raise_done_ff <= raise_done_in;
         switched_ff   <= switched_in;
         applied_ff    <= applied_in;
         new_form_ff   <= new_form_in;
      end
   end

   // next candidate baud index, wrapped at the candidate count
   always_comb begin
      wrap_v = {1'b0, baud_ff} + 4'd1;
      for (int k = 0; k < 4; k++) begin
         if (wrap_v >= 4'(BAUD_COUNT)) begin
            wrap_v = wrap_v - 4'(BAUD_COUNT);
         end
      end
      baud_wrap = wrap_v[2:0];
   end

   always_comb begin
      logic [31:0] since;
      logic [17:0] rate;
      logic        do_probe;
      logic        do_config;
      logic        do_finish;
      logic        do_retune;

      mode_in       = mode_ff;
      baud_in       = baud_ff;
      prior_in      = prior_ff;
      good_in       = good_ff;
      attempt_in    = attempt_ff;
      entered_in    = entered_ff;
      last_frame_in = last_frame_ff;
      last_pos_in   = last_pos_ff;
      ack_in        = ack_ff;
      pos_seen_in   = pos_seen_ff;
      raise_done_in = raise_done_ff;
      switched_in   = switched_ff;
      applied_in    = applied_ff;
      new_form_in   = new_form_ff;
      res           = '0;
      do_probe      = 1'b0;
      do_config     = 1'b0;
      do_finish     = 1'b0;
      do_retune     = 1'b0;
      since         = in_now_ff - entered_ff;
      rate          = BAUD_RATE_TABLE[baud_ff];

      case (in_op_ff)
         OP_TICK: begin
            case (mode_ff)
               MODE_PROBE: begin
                  if (good_ff >= 2'(PROBE_FRAMES)) begin
                     do_config = 1'b1;
                  end else if (since > {16'd0, probe_dwell_ff}) begin
                     baud_in  = baud_wrap;
                     do_probe = 1'b1;
                  end
               end
               MODE_NEWCFG: begin
                  if (ack_ff == ACK_OK) begin
                     new_form_in = 1'b1;
                     do_finish   = 1'b1;
                  end else if (ack_ff == ACK_NAK || since > {16'd0, ack_timeout_ff}) begin
                     res.send_legacy_config = 1'b1;
                     ack_in     = ACK_IDLE;
                     mode_in    = MODE_LEGACY;
                     entered_in = in_now_ff;
                  end
               end
               MODE_LEGACY: begin
                  if (ack_ff == ACK_OK) begin
                     new_form_in      = 1'b0;
                     res.disable_nmea = 1'b1;
                     do_finish        = 1'b1;
                  end else if (ack_ff == ACK_NAK || since > {16'd0, ack_timeout_ff}) begin
                     mode_in    = MODE_RUN;
                     entered_in = in_now_ff;
                  end
               end
               MODE_RAISE: begin
                  if (!switched_ff) begin
                     if (since > {16'd0, baud_settle_ff}) begin
                        res.drain_tx = 1'b1;
                        prior_in     = baud_ff;
                        baud_in      = 3'(FAST_BAUD_INDEX);
                        do_retune    = 1'b1;
                        switched_in  = 1'b1;
                        entered_in   = in_now_ff;
                     end
                  end else if (pos_seen_ff) begin
                     res.nav_rate_ms = NAV_RATE_FAST;
                     ack_in          = ACK_IDLE;
                     last_pos_in     = in_now_ff;
                     mode_in         = MODE_RUN;
                     entered_in      = in_now_ff;
                  end else if (since > {16'd0, baud_verify_ff}) begin
                     baud_in       = prior_ff;
                     do_retune     = 1'b1;
                     last_frame_in = in_now_ff;
                     last_pos_in   = in_now_ff;
                     mode_in       = MODE_RUN;
                     entered_in    = in_now_ff;
                  end
               end
               MODE_RUN: begin
                  if (in_now_ff - last_frame_ff > {16'd0, silence_ff}) begin
                     applied_in = 1'b0;
                     do_probe   = 1'b1;
                  end else if (applied_ff &&
                               in_now_ff - last_pos_ff > {16'd0, silence_ff}) begin
                     applied_in = 1'b0;
                     do_config  = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         OP_FRAME: begin
            last_frame_in = in_now_ff;
            if (mode_ff == MODE_PROBE && good_ff < 2'(PROBE_FRAMES)) begin
               good_in = good_ff + 2'd1;
            end
         end
         OP_ACK: ack_in = ACK_OK;
         OP_NAK: ack_in = ACK_NAK;
         OP_POSITION: begin
            last_frame_in = in_now_ff;
            if (mode_ff == MODE_PROBE && good_ff < 2'(PROBE_FRAMES)) begin
               good_in = good_ff + 2'd1;
            end
            pos_seen_in = 1'b1;
            last_pos_in = in_now_ff;
         end
         default: ;
      endcase

      // accepted configuration: pick nav rate, maybe raise baud
      if (do_finish) begin
         applied_in  = 1'b1;
         last_pos_in = in_now_ff;
         ack_in      = ACK_IDLE;
         entered_in  = in_now_ff;
         if (rate >= BAUD_MID) begin
            res.nav_rate_ms = NAV_RATE_FAST;
         end else if (rate >= BAUD_LOW) begin
            res.nav_rate_ms = NAV_RATE_MID;
         end else begin
            res.nav_rate_ms = NAV_RATE_SLOW;
         end
         if (rate < BAUD_MID && !raise_done_ff) begin
            raise_done_in        = 1'b1;
            res.send_baud_change = 1'b1;
            switched_in          = 1'b0;
            mode_in              = MODE_RAISE;
         end else begin
            mode_in = MODE_RUN;
         end
      end

      if (do_config) begin
         entered_in = in_now_ff;
         if (!tx_present_ff || attempt_ff >= max_attempts_ff) begin
            mode_in = MODE_RUN;
         end else begin
            if (attempt_ff < ATTEMPT_MAX) begin
               attempt_in = attempt_ff + 2'd1;
            end
            res.send_new_config = 1'b1;
            ack_in              = ACK_IDLE;
            mode_in             = MODE_NEWCFG;
         end
      end

      if (do_probe) begin
         good_in       = 2'd0;
         raise_done_in = 1'b0;
         mode_in       = MODE_PROBE;
         entered_in    = in_now_ff;
         do_retune     = 1'b1;
      end

      if (do_retune) begin
         res.port_retune = 1'b1;
         ack_in          = ACK_IDLE;
         pos_seen_in     = 1'b0;
      end

      res.mode            = mode_in;
      res.port_baud_index = baud_in;
      res.config_applied  = applied_in;
      res.used_new_config = new_form_in;
   end

   assign rsp_if.valid              = out_valid_ff;
   assign rsp_if.mode               = out_ff.mode;
   assign rsp_if.port_baud_index    = out_ff.port_baud_index;
   assign rsp_if.port_retune        = out_ff.port_retune;
   assign rsp_if.drain_tx           = out_ff.drain_tx;
   assign rsp_if.send_new_config    = out_ff.send_new_config;
   assign rsp_if.send_legacy_config = out_ff.send_legacy_config;
   assign rsp_if.disable_nmea       = out_ff.disable_nmea;
   assign rsp_if.nav_rate_ms        = out_ff.nav_rate_ms;
   assign rsp_if.send_baud_change   = out_ff.send_baud_change;
   assign rsp_if.config_applied     = out_ff.config_applied;
   assign rsp_if.used_new_config    = out_ff.used_new_config;

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("stepped event did not produce a result");

   a_baud_change_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.send_baud_change) |-> out_ff.mode == MODE_RAISE)
      else $error("baud change request outside baud raise");

   a_new_config_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.send_new_config) |-> out_ff.mode == MODE_NEWCFG)
      else $error("new config queued outside new config mode");

   a_rate_applied: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.nav_rate_ms != 9'd0) |-> out_ff.config_applied)
      else $error("nav rate requested without applied configuration");

   a_good_bounded: assert property (@(posedge clock) disable iff (reset)
      good_ff <= 2'(PROBE_FRAMES))
      else $error("good frame count beyond probe limit");

endmodule
